@@ design/cpa_pkg.sv @@
// Shared types, codes and constants of the chunk pool allocator.
package cpa_pkg;

    localparam int ACTION_W = 1;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;
    localparam int OFFSET_W = 26;
    localparam int COUNT_W  = 11;
    localparam int BYTES_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [ACTION_W-1:0] ACTION_ALLOC = 1'b0;
    localparam logic [ACTION_W-1:0] ACTION_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BYTES = 2'd1;

    localparam logic [BYTES_W-1:0] CHUNK_BYTES_RESET = 16'd64;
    localparam logic [BYTES_W-1:0] MIN_CHUNK_BYTES   = 16'd16;
    localparam logic [COUNT_W-1:0] FREE_SAT          = 11'd2047;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic commit;
    } cmd_t;

endpackage

@@ design/cpa_req_if.sv @@
// Request channel: action and chunk index with a valid/ready handshake.
interface cpa_req_if;
    logic                           valid;
    logic                           ready;
    logic [cpa_pkg::ACTION_W-1:0]   action;
    logic [cpa_pkg::INDEX_W-1:0]    free_index;

    modport source (output valid, output action, output free_index, input ready);
    modport sink   (input valid, input action, input free_index, output ready);
endinterface

@@ design/cpa_rsp_if.sv @@
// Result channel: status, chunk, byte offset and free count with a valid/ready handshake.
interface cpa_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [cpa_pkg::STATUS_W-1:0]   status;
    logic [cpa_pkg::INDEX_W-1:0]    chunk_index;
    logic [cpa_pkg::OFFSET_W-1:0]   byte_offset;
    logic [cpa_pkg::COUNT_W-1:0]    chunks_free;

    modport source (output valid, output status, output chunk_index, output byte_offset,
                    output chunks_free, input ready);
    modport sink   (input valid, input status, input chunk_index, input byte_offset,
                    input chunks_free, output ready);
endinterface

@@ design/cpa_ctrl.sv @@
// Controller state machine: request acceptance, commit timing and result valid.
module cpa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output cpa_pkg::cmd_t cmd
);
    import cpa_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;
    logic commit;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    // A finished request waits in the execute state until the result slot frees up.
    assign commit   = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    assign cmd.load   = accept;
    assign cmd.commit = commit;
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted request did not move to execute");

    a_commit_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (state_reg == ST_EXEC))
        else $error("commit outside execute state");

    a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("committed request produced no result");

endmodule

@@ design/cpa_datapath.sv @@
// Datapath: run table memory, head pointer, free count, configuration and result register.
module cpa_datapath #(
    parameter int MAX_CHUNKS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cpa_pkg::cmd_t                    cmd,
    input  logic                             cfg_we,
    input  logic [cpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cpa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [cpa_pkg::ACTION_W-1:0]     in_action,
    input  logic [cpa_pkg::INDEX_W-1:0]      in_free_index,
    output logic [cpa_pkg::STATUS_W-1:0]     out_status,
    output logic [cpa_pkg::INDEX_W-1:0]      out_chunk_index,
    output logic [cpa_pkg::OFFSET_W-1:0]     out_byte_offset,
    output logic [cpa_pkg::COUNT_W-1:0]      out_chunks_free
);
    import cpa_pkg::*;

    localparam int AW = $clog2(MAX_CHUNKS);
    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int PW = AW + BYTES_W;
    localparam logic [CW-1:0] NULL_PTR = CW'(MAX_CHUNKS);
    localparam logic [COUNT_W-1:0] COUNT_RESET =
        (MAX_CHUNKS < 1024) ? COUNT_W'(MAX_CHUNKS) : 11'd1024;

    // Each entry holds the run length in the upper half and the successor in the lower.
    logic [2*CW-1:0] mem [MAX_CHUNKS];

    logic [CW-1:0]         head_reg;
    logic [CW-1:0]         head_next;
    logic [COUNT_W-1:0]    free_total_reg;
    logic [COUNT_W-1:0]    free_total_next;
    logic [COUNT_W-1:0]    chunk_count_reg;
    logic [BYTES_W-1:0]    chunk_bytes_reg;
    logic                  e0_valid_reg;
    logic [ACTION_W-1:0]   action_reg;
    logic [INDEX_W-1:0]    idx_reg;
    logic [2*CW-1:0]       rd_data_reg;
    logic                  rd_default_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [INDEX_W-1:0]    chunk_index_reg;
    logic [OFFSET_W-1:0]   byte_offset_reg;
    logic [COUNT_W-1:0]    chunks_free_reg;

    logic [CW-1:0]         rd_len;
    logic [CW-1:0]         rd_next;
    logic [CW-1:0]         head_plus;
    logic                  alloc_empty;
    logic                  can_split;
    logic                  idx_bad;
    logic [PW-1:0]         prod;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [2*CW-1:0]       mem_wdata;
    logic [STATUS_W-1:0]   status_c;
    logic                  got_ok;

    logic [COUNT_W-1:0]    cc_raw;
    logic [COUNT_W-1:0]    cc_nz;
    logic [COUNT_W-1:0]    cc_new;
    logic                  bytes_ok;

    // Entry 0 reads as the initial full run until the first write after a pool reset.
    assign rd_len  = rd_default_reg ? CW'(chunk_count_reg) : rd_data_reg[2*CW-1:CW];
    assign rd_next = rd_default_reg ? NULL_PTR : rd_data_reg[CW-1:0];

    assign head_plus   = head_reg + CW'(1);
    assign alloc_empty = (free_total_reg == '0) || (head_reg >= NULL_PTR);
    assign can_split   = (rd_len > CW'(1)) && (head_plus < NULL_PTR);
    assign idx_bad     = LW'(idx_reg) >= LW'(chunk_count_reg);
    assign prod        = head_reg[AW-1:0] * chunk_bytes_reg;

    always_comb
    begin
        head_next       = head_reg;
        free_total_next = free_total_reg;
        mem_we          = 1'b0;
        mem_waddr       = head_plus[AW-1:0];
        mem_wdata       = {rd_len - CW'(1), rd_next};
        status_c        = STATUS_OK;
        got_ok          = 1'b0;
        case (action_reg)
            ACTION_ALLOC:
            begin
                if (alloc_empty)
                begin
                    status_c = STATUS_EMPTY;
                end
                else
                begin
                    got_ok          = 1'b1;
                    free_total_next = free_total_reg - COUNT_W'(1);
                    if (can_split)
                    begin
                        mem_we    = 1'b1;
                        head_next = head_plus;
                    end
                    else
                    begin
                        head_next = rd_next;
                    end
                end
            end
            ACTION_FREE:
            begin
                if (idx_bad)
                begin
                    status_c = STATUS_RANGE;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(idx_reg);
                    mem_wdata = {CW'(1), head_reg};
                    head_next = CW'(idx_reg);
                    if (free_total_reg < FREE_SAT)
                    begin
                        free_total_next = free_total_reg + COUNT_W'(1);
                    end
                end
            end
            default:
            begin
                status_c = STATUS_OK;
            end
        endcase
    end

    // Configuration value checks.
    assign cc_raw   = cfg_data[COUNT_W-1:0];
    assign cc_nz    = (cc_raw == '0) ? COUNT_W'(1) : cc_raw;
    assign cc_new   = (LW'(cc_nz) > LW'(MAX_CHUNKS)) ? COUNT_W'(MAX_CHUNKS) : cc_nz;
    assign bytes_ok = (cfg_data >= MIN_CHUNK_BYTES) && (cfg_data[1:0] == 2'b00);

    always_ff @(posedge clk)
    begin
        if (cmd.commit && mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rd_data_reg    <= mem[head_reg[AW-1:0]];
            rd_default_reg <= (head_reg == '0) && !e0_valid_reg;
            action_reg     <= in_action;
            idx_reg        <= in_free_index;
        end
        if (cmd.commit)
        begin
            status_reg      <= status_c;
            chunk_index_reg <= got_ok ? INDEX_W'(head_reg[AW-1:0]) : '0;
            byte_offset_reg <= got_ok ? OFFSET_W'(prod) : '0;
            chunks_free_reg <= free_total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_count_reg <= COUNT_RESET;
            chunk_bytes_reg <= CHUNK_BYTES_RESET;
            head_reg        <= '0;
            free_total_reg  <= COUNT_RESET;
            e0_valid_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            // Every write, accepted or not, restores one full run at chunk 0.
            head_reg     <= '0;
            e0_valid_reg <= 1'b0;
            case (cfg_index)
                REG_CHUNK_COUNT:
                begin
                    chunk_count_reg <= cc_new;
                    free_total_reg  <= cc_new;
                end
                REG_CHUNK_BYTES:
                begin
                    if (bytes_ok)
                    begin
                        chunk_bytes_reg <= cfg_data;
                    end
                    free_total_reg <= chunk_count_reg;
                end
                default:
                begin
                    free_total_reg <= chunk_count_reg;
                end
            endcase
        end
        else if (cmd.commit)
        begin
            head_reg       <= head_next;
            free_total_reg <= free_total_next;
            if (mem_we && (mem_waddr == '0))
            begin
                e0_valid_reg <= 1'b1;
            end
        end
    end

    assign out_status      = status_reg;
    assign out_chunk_index = chunk_index_reg;
    assign out_byte_offset = byte_offset_reg;
    assign out_chunks_free = chunks_free_reg;

    a_alloc_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !cfg_we && (action_reg == ACTION_ALLOC) && !alloc_empty)
        |=> (free_total_reg == $past(free_total_reg) - COUNT_W'(1)))
        else $error("successful allocate did not lower the free count");

    a_cfg_resets_pool: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (!e0_valid_reg && (head_reg == '0)))
        else $error("configuration write did not restore the initial run");

    a_result_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !cfg_we) |=> (chunks_free_reg == free_total_reg))
        else $error("reported free count differs from the pool count");

endmodule

@@ design/chunk_pool_allocator.sv @@
// Top level of the chunk pool allocator: controller plus datapath.
//
//  Channel   Direction  Handshake     Payload
//  cfg       in         cfg_we        cfg_index, cfg_data (no ready, no read-back)
//  req       in         valid/ready   action, free_index
//  rsp       out        valid/ready   status, chunk_index, byte_offset, chunks_free
//
// Each request is accepted in the idle state, which registers the head entry of the
// run table memory; the execute state then computes the update and writes the memory,
// so the synchronous memory read in front of the head update keeps one request in flight.
// A request is accepted while an earlier result still waits; it then holds in
// the execute state until the result register frees up.
// Reset (rst_n, asynchronous) needs no clearing pass; requests are taken at once.
module chunk_pool_allocator #(
    parameter int MAX_CHUNKS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cpa_pkg::CFG_DATA_W-1:0]  cfg_data,
    cpa_req_if.sink                         req,
    cpa_rsp_if.source                       rsp
);
    import cpa_pkg::*;

    cmd_t cmd;
    logic in_ready;
    logic out_valid;

    cpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    cpa_datapath #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_action       (req.action),
        .in_free_index   (req.free_index),
        .out_status      (rsp.status),
        .out_chunk_index (rsp.chunk_index),
        .out_byte_offset (rsp.byte_offset),
        .out_chunks_free (rsp.chunks_free)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

endmodule
